// ===== sv/gcs_pkg.sv =====
// gcs_pkg: shared types and constants for the grey contrast stretch block.
// Used by gcs_ctrl, gcs_datapath and grey_contrast_stretch; no dependencies.
package gcs_pkg;

	localparam int PIX_W     = 8;
	localparam int OPC_W     = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	// quotient bits produced by the serial divider, one per cycle
	localparam int DIV_STEPS = 9;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [OPC_W-1:0] {
		OP_MEASURE = 2'd0,
		OP_MAP     = 2'd1,
		OP_CLEAR   = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUT_LOW  = 1'd0,
		REG_OUT_HIGH = 1'd1
	} reg_idx_t;

	// controller to datapath commands
	typedef struct packed {
		logic stat_measure;
		logic stat_clear;
		logic map_start;
		logic mul_load;
		logic abs_load;
		logic div_step;
		logic out_load;
	} gcs_cmd_t;

endpackage

// ===== sv/gcs_ctrl.sv =====
// gcs_ctrl: sequencer for measure, clear and map words and the output handshake.
// Depends on gcs_pkg; drives the gcs_datapath command struct.
module gcs_ctrl
	import gcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OPC_W-1:0] opcode,
	output logic             out_valid,
	input  logic             out_ready,
	output gcs_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ABS,
		S_DIV,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             in_acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign in_acc    = in_valid && in_ready;

	always_comb begin
		cmd              = '0;
		cmd.stat_measure = in_acc && (opcode == OP_MEASURE);
		cmd.stat_clear   = in_acc && (opcode == OP_CLEAR);
		cmd.map_start    = in_acc && (opcode == OP_MAP);
		cmd.mul_load     = (state_q == S_MUL);
		cmd.abs_load     = (state_q == S_ABS);
		cmd.div_step     = (state_q == S_DIV);
		cmd.out_load     = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.map_start)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ABS;
				S_ABS: begin
					state_q <= S_DIV;
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= S_FIN;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				S_FIN: begin
					if (cmd.out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/gcs_datapath.sv =====
// gcs_datapath: min/max statistics, settings, multiplier, serial divider, output word.
// Depends on gcs_pkg; steered by the gcs_ctrl command struct.
module gcs_datapath
	import gcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  gcs_cmd_t             cmd,
	input  logic [PIX_W-1:0]     pixel,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output logic [PIX_W-1:0]     out_pixel
);

	localparam int PROD_W = 2 * (PIX_W + 1);   // signed product
	localparam int MAG_W  = PROD_W - 1;        // |2*prod + d| fits here
	localparam int VAL_W  = PIX_W + 3;         // low + signed quotient

	// settings and statistics
	logic [PIX_W-1:0] out_low_q, out_high_q;
	logic [PIX_W-1:0] min_q, max_q;
	// working registers
	logic [PIX_W-1:0]         pix_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [PIX_W-1:0]         d_q;
	logic                     flat_q;
	logic [MAG_W-1:0]         a_s2;
	logic                     neg_s2;
	logic [MAG_W-1:0]         rem_q;
	logic [MAG_W-1:0]         div_q;
	logic [DIV_STEPS-1:0]     quo_q;
	logic                     sat_q;
	logic [PIX_W-1:0]         out_pixel_q;

	logic signed [PIX_W:0]    diff_hl, diff_pm;
	logic signed [PROD_W-1:0] m_val;
	logic [PROD_W-1:0]        m_neg;
	logic [PROD_W-1:0]        sat_lim;
	logic [DIV_STEPS:0]       qa;
	logic signed [VAL_W-1:0]  qs, val;
	logic [PIX_W-1:0]         res;

	assign out_pixel = out_pixel_q;

	// settings write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_low_q  <= '0;
			out_high_q <= '1;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_OUT_LOW:  out_low_q  <= wr_data[PIX_W-1:0];
				REG_OUT_HIGH: out_high_q <= wr_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// running min / max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '1;
			max_q <= '0;
		end else if (cmd.stat_clear) begin
			min_q <= '1;
			max_q <= '0;
		end else if (cmd.stat_measure) begin
			if (pixel > max_q)
				max_q <= pixel;
			if (pixel < min_q)
				min_q <= pixel;
		end
	end

	// stage 1: (high - low) * (pixel - min)
	assign diff_hl = $signed({1'b0, out_high_q}) - $signed({1'b0, out_low_q});
	assign diff_pm = $signed({1'b0, pix_q}) - $signed({1'b0, min_q});

	// stage 2: M = 2*prod + d, split into sign and magnitude
	assign m_val = (prod_s1 <<< 1) + $signed({{(PROD_W-PIX_W){1'b0}}, d_q});
	assign m_neg = -m_val;

	// quotient of 512 or more always clamps
	assign sat_lim = {d_q, 10'b0};

	always_ff @(posedge clk) begin
		if (cmd.map_start)
			pix_q <= pixel;
		if (cmd.mul_load) begin
			prod_s1 <= diff_hl * diff_pm;
			d_q     <= max_q - min_q;
			flat_q  <= (max_q <= min_q);
		end
		if (cmd.abs_load) begin
			neg_s2 <= m_val[PROD_W-1];
			a_s2   <= m_val[PROD_W-1] ? m_neg[MAG_W-1:0] : m_val[MAG_W-1:0];
			rem_q  <= m_val[PROD_W-1] ? m_neg[MAG_W-1:0] : m_val[MAG_W-1:0];
			div_q  <= {d_q, {(MAG_W-PIX_W){1'b0}}};   // 2d << 8
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			sat_q <= {1'b0, a_s2} >= sat_lim;
			if (rem_q >= div_q) begin
				rem_q <= rem_q - div_q;
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
			end
			div_q <= div_q >> 1;
		end
		if (cmd.out_load)
			out_pixel_q <= res;
	end

	// final: floor for negative numerators, add low, clamp
	assign qa  = {1'b0, quo_q} + (DIV_STEPS+1)'(neg_s2 && (rem_q != '0));
	assign qs  = neg_s2 ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
	assign val = $signed({3'b000, out_low_q}) + qs;

	always_comb begin
		if (flat_q)
			res = out_low_q;
		else if (sat_q)
			res = neg_s2 ? '0 : '1;
		else if (val < 0)
			res = '0;
		else if (val > $signed(VAL_W'(255)))
			res = '1;
		else
			res = val[PIX_W-1:0];
	end

endmodule

// ===== sv/grey_contrast_stretch.sv =====
// grey_contrast_stretch: top level, min/max contrast stretch of 8-bit grey values.
// Depends on gcs_pkg, gcs_ctrl and gcs_datapath.
//
// Each input word carries an opcode and a pixel. A measure word folds the pixel
// into the running minimum and maximum and gives no output; a clear word returns
// them to their reset values (min 255, max 0). A map word gives one output word:
// out_low + (out_high - out_low) * (pixel - min) / (max - min), rounded half up
// and clamped to 0..255; with no measured range (max not above min) it gives
// out_low. Opcode 3 is swallowed. Measure, clear and unused words leave the
// block idle. A map word holds the input through the multiply, the forming of
// the signed numerator, the one-bit-per-cycle restoring divider and the step
// that rounds, clamps and loads the output register; it waits longer only if
// the previous output word has not been taken. The output register lets the
// next word be accepted while a result is still waiting.
// out_low (index 0) and out_high (index 1) are written through wr_en, wr_index
// and wr_data, and should only be changed while the block is idle.
module grey_contrast_stretch
	import gcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input words
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OPC_W-1:0]     opcode,
	input  logic [PIX_W-1:0]     pixel,
	// output words
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     out_pixel,
	// settings
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data
);

	gcs_cmd_t cmd;

	// sequencing and handshakes
	gcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// statistics, arithmetic and output register
	gcs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pixel     (pixel),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.out_pixel (out_pixel)
	);

endmodule
